>>> hw/rtl/phfte_pkg.sv
// Shared types and constants for the packet header five-tuple extractor.
// No dependencies; the capture stage and the top level refer to it by scoped names.
package phfte_pkg;

   localparam int PosWidth = 7;

   // Frame byte offsets and lengths.
   localparam logic [PosWidth-1:0] POS_MAX       = 7'd127;
   localparam logic [PosWidth-1:0] POS_ETYPE_HI  = 7'd12;
   localparam logic [PosWidth-1:0] POS_ETYPE_LO  = 7'd13;
   localparam logic [PosWidth-1:0] ETH_HDR_LEN   = 7'd14;
   localparam logic [PosWidth-1:0] IPV6_TS       = 7'd54;
   localparam logic [PosWidth-1:0] V4_POS_LEN_HI = 7'd16;
   localparam logic [PosWidth-1:0] V4_POS_LEN_LO = 7'd17;
   localparam logic [PosWidth-1:0] V4_POS_PROTO  = 7'd23;
   localparam logic [PosWidth-1:0] V6_POS_LEN_HI = 7'd18;
   localparam logic [PosWidth-1:0] V6_POS_LEN_LO = 7'd19;
   localparam logic [PosWidth-1:0] V6_POS_NEXT   = 7'd20;
   localparam logic [1:0]          IHL_SHIFT     = 2'd2;

   // EtherType values.
   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

   // IP kind codes.
   localparam logic [1:0] KIND_UNKNOWN = 2'd0;
   localparam logic [1:0] KIND_IPV4    = 2'd1;
   localparam logic [1:0] KIND_IPV6    = 2'd2;

   // Protocol numbers.
   localparam logic [7:0] PROTO_ICMP  = 8'd1;
   localparam logic [7:0] PROTO_IGMP  = 8'd2;
   localparam logic [7:0] PROTO_TCP   = 8'd6;
   localparam logic [7:0] PROTO_UDP   = 8'd17;
   localparam logic [7:0] PROTO_ICMP6 = 8'd58;

   // Protocol class codes.
   localparam logic [2:0] CLASS_TCP     = 3'd0;
   localparam logic [2:0] CLASS_UDP     = 3'd1;
   localparam logic [2:0] CLASS_ICMP    = 3'd2;
   localparam logic [2:0] CLASS_IGMP    = 3'd3;
   localparam logic [2:0] CLASS_ICMP6   = 3'd4;
   localparam logic [2:0] CLASS_UNKNOWN = 3'd5;

   // One five-tuple record as handed from the capture stage to the result register.
   typedef struct packed {
      logic [1:0]  ip_kind;
      logic [63:0] src_addr_high;
      logic [63:0] src_addr_low;
      logic [63:0] dst_addr_high;
      logic [63:0] dst_addr_low;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic        ports_valid;
      logic [2:0]  protocol_class;
      logic [15:0] ip_length;
      logic        truncated;
   } record_type;

endpackage

>>> hw/rtl/phfte_capture.sv
// Per-frame capture state of the five-tuple extractor and the record built from it.
// Depends on phfte_pkg for offsets, codes and the record type.
module phfte_capture (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   input  logic                   last,
   output phfte_pkg::record_type  record
);

   logic [6:0]  pos_ff,   pos_in;
   logic [15:0] etype_ff, etype_in;
   logic [1:0]  kind_ff,  kind_in;
   logic [6:0]  ts_ff,    ts_in;
   logic [7:0]  proto_ff, proto_in;
   logic [63:0] src_hi_ff, src_hi_in, src_lo_ff, src_lo_in;
   logic [63:0] dst_hi_ff, dst_hi_in, dst_lo_ff, dst_lo_in;
   logic [15:0] len_ff,   len_in;
   logic [15:0] sport_ff, sport_in;
   logic [15:0] dport_ff, dport_in;

   // Values after this byte is applied, before the end-of-frame clear.
   logic [15:0] etype_upd;
   logic [1:0]  kind_upd;
   logic [6:0]  ts_upd;
   logic [7:0]  proto_upd;
   logic [63:0] src_hi_upd, src_lo_upd, dst_hi_upd, dst_lo_upd;
   logic [15:0] len_upd, sport_upd, dport_upd;
   logic [6:0]  p;
   logic [7:0]  n, ts_end;
   logic        v4, v6, tu, in_ports;
   logic        have_len, have_proto, have_src, have_dst, have_ports;
   logic [7:0]  prot;

   assign p = pos_ff;

   // Field capture for the current byte.
   always_comb begin
      etype_upd  = etype_ff;
      kind_upd   = kind_ff;
      ts_upd     = ts_ff;
      proto_upd  = proto_ff;
      src_hi_upd = src_hi_ff;
      src_lo_upd = src_lo_ff;
      dst_hi_upd = dst_hi_ff;
      dst_lo_upd = dst_lo_ff;
      len_upd    = len_ff;
      sport_upd  = sport_ff;
      dport_upd  = dport_ff;

      // EtherType and header kind.
      if (p == phfte_pkg::POS_ETYPE_HI) begin
         etype_upd = {data_byte, 8'h00};
      end
      if (p == phfte_pkg::POS_ETYPE_LO) begin
         etype_upd = {etype_ff[15:8], etype_ff[7:0] | data_byte};
         if (etype_upd == phfte_pkg::ETYPE_IPV4) begin
            kind_upd = phfte_pkg::KIND_IPV4;
         end else if (etype_upd == phfte_pkg::ETYPE_IPV6) begin
            kind_upd = phfte_pkg::KIND_IPV6;
            ts_upd   = phfte_pkg::IPV6_TS;
         end else begin
            kind_upd = phfte_pkg::KIND_UNKNOWN;
         end
      end

      // IP header fields.
      if (kind_upd == phfte_pkg::KIND_IPV4) begin
         if (p == phfte_pkg::ETH_HDR_LEN) begin
            ts_upd = phfte_pkg::ETH_HDR_LEN + ({3'b000, data_byte[3:0]} << phfte_pkg::IHL_SHIFT);
         end
         if (p == phfte_pkg::V4_POS_LEN_HI) len_upd = {data_byte, 8'h00};
         if (p == phfte_pkg::V4_POS_LEN_LO) len_upd = {len_ff[15:8], len_ff[7:0] | data_byte};
         if (p == phfte_pkg::V4_POS_PROTO)  proto_upd = data_byte;
         if (p >= 7'd26 && p <= 7'd29) src_lo_upd = {src_lo_ff[55:0], data_byte};
         if (p >= 7'd30 && p <= 7'd33) dst_lo_upd = {dst_lo_ff[55:0], data_byte};
      end else if (kind_upd == phfte_pkg::KIND_IPV6) begin
         if (p == phfte_pkg::V6_POS_LEN_HI) len_upd = {data_byte, 8'h00};
         if (p == phfte_pkg::V6_POS_LEN_LO) len_upd = {len_ff[15:8], len_ff[7:0] | data_byte};
         if (p == phfte_pkg::V6_POS_NEXT)   proto_upd = data_byte;
         if (p >= 7'd22 && p <= 7'd29) src_hi_upd = {src_hi_ff[55:0], data_byte};
         if (p >= 7'd30 && p <= 7'd37) src_lo_upd = {src_lo_ff[55:0], data_byte};
         if (p >= 7'd38 && p <= 7'd45) dst_hi_upd = {dst_hi_ff[55:0], data_byte};
         if (p >= 7'd46 && p <= 7'd53) dst_lo_upd = {dst_lo_ff[55:0], data_byte};
      end

      // Transport ports: the first four bytes after the IP header.
      ts_end   = {1'b0, ts_upd} + 8'd4;
      in_ports = (kind_upd != phfte_pkg::KIND_UNKNOWN) && (p >= phfte_pkg::ETH_HDR_LEN)
                 && (p >= ts_upd) && ({1'b0, p} < ts_end);
      if (in_ports) begin
         if ({1'b0, p} < ({1'b0, ts_upd} + 8'd2)) begin
            sport_upd = {sport_ff[7:0], data_byte};
         end else begin
            dport_upd = {dport_ff[7:0], data_byte};
         end
      end
   end

   // Record for a frame that ends on this byte.
   always_comb begin
      n          = {1'b0, p} + 8'd1;
      v4         = (kind_upd == phfte_pkg::KIND_IPV4);
      v6         = (kind_upd == phfte_pkg::KIND_IPV6);
      have_len   = (v4 && n >= 8'd18) || (v6 && n >= 8'd20);
      have_proto = (v4 && n >= 8'd24) || (v6 && n >= 8'd21);
      have_src   = (v4 && n >= 8'd30) || (v6 && n >= 8'd38);
      have_dst   = (v4 && n >= 8'd34) || (v6 && n >= 8'd54);
      prot       = have_proto ? proto_upd : 8'd0;
      tu         = (prot == phfte_pkg::PROTO_TCP) || (prot == phfte_pkg::PROTO_UDP);
      have_ports = tu && (n >= ts_end);

      record.ip_kind       = kind_upd;
      record.src_addr_high = have_src ? src_hi_upd : 64'd0;
      record.src_addr_low  = have_src ? src_lo_upd : 64'd0;
      record.dst_addr_high = have_dst ? dst_hi_upd : 64'd0;
      record.dst_addr_low  = have_dst ? dst_lo_upd : 64'd0;
      record.src_port      = have_ports ? sport_upd : 16'd0;
      record.dst_port      = have_ports ? dport_upd : 16'd0;
      record.ports_valid   = have_ports;
      record.ip_length     = have_len ? len_upd : 16'd0;

      case (prot)
         phfte_pkg::PROTO_TCP:   record.protocol_class = phfte_pkg::CLASS_TCP;
         phfte_pkg::PROTO_UDP:   record.protocol_class = phfte_pkg::CLASS_UDP;
         phfte_pkg::PROTO_ICMP:  record.protocol_class = phfte_pkg::CLASS_ICMP;
         phfte_pkg::PROTO_IGMP:  record.protocol_class = phfte_pkg::CLASS_IGMP;
         phfte_pkg::PROTO_ICMP6: record.protocol_class = phfte_pkg::CLASS_ICMP6;
         default:                record.protocol_class = phfte_pkg::CLASS_UNKNOWN;
      endcase

      if (n < {1'b0, phfte_pkg::ETH_HDR_LEN}) begin
         record.truncated = 1'b1;
      end else if (v4 || v6) begin
         record.truncated = !have_dst || (tu && !have_ports);
      end else begin
         record.truncated = 1'b0;
      end
   end

   // Next state: hold when idle, clear at end of frame, else take the updated fields.
   always_comb begin
      pos_in    = pos_ff;
      etype_in  = etype_ff;
      kind_in   = kind_ff;
      ts_in     = ts_ff;
      proto_in  = proto_ff;
      src_hi_in = src_hi_ff;
      src_lo_in = src_lo_ff;
      dst_hi_in = dst_hi_ff;
      dst_lo_in = dst_lo_ff;
      len_in    = len_ff;
      sport_in  = sport_ff;
      dport_in  = dport_ff;
      if (step) begin
         if (last) begin
            pos_in    = '0;
            etype_in  = '0;
            kind_in   = phfte_pkg::KIND_UNKNOWN;
            ts_in     = '0;
            proto_in  = '0;
            src_hi_in = '0;
            src_lo_in = '0;
            dst_hi_in = '0;
            dst_lo_in = '0;
            len_in    = '0;
            sport_in  = '0;
            dport_in  = '0;
         end else begin
            pos_in    = (pos_ff != phfte_pkg::POS_MAX) ? pos_ff + 7'd1 : pos_ff;
            etype_in  = etype_upd;
            kind_in   = kind_upd;
            ts_in     = ts_upd;
            proto_in  = proto_upd;
            src_hi_in = src_hi_upd;
            src_lo_in = src_lo_upd;
            dst_hi_in = dst_hi_upd;
            dst_lo_in = dst_lo_upd;
            len_in    = len_upd;
            sport_in  = sport_upd;
            dport_in  = dport_upd;
         end
      end
   end

   // Capture registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         etype_ff  <= '0;
         kind_ff   <= phfte_pkg::KIND_UNKNOWN;
         ts_ff     <= '0;
         proto_ff  <= '0;
         src_hi_ff <= '0;
         src_lo_ff <= '0;
         dst_hi_ff <= '0;
         dst_lo_ff <= '0;
         len_ff    <= '0;
         sport_ff  <= '0;
         dport_ff  <= '0;
      end else begin
         pos_ff    <= pos_in;
         etype_ff  <= etype_in;
         kind_ff   <= kind_in;
         ts_ff     <= ts_in;
         proto_ff  <= proto_in;
         src_hi_ff <= src_hi_in;
         src_lo_ff <= src_lo_in;
         dst_hi_ff <= dst_hi_in;
         dst_lo_ff <= dst_lo_in;
         len_ff    <= len_in;
         sport_ff  <= sport_in;
         dport_ff  <= dport_in;
      end
   end

endmodule

>>> hw/rtl/packet_header_five_tuple_extractor_unit.sv
// Packet header five-tuple extractor: input register, capture stage, result register.
// Throughput: one frame byte per cycle through the single capture stage, except while a last byte is held.
// A last byte goes from the input register into the result register, which raises rsp_valid with its record.
// Bytes keep flowing while a record waits; only a last byte is held until the result frees.
// Synchronous active-high reset clears all per-frame state and empties both registers.
// Depends on phfte_pkg and phfte_capture.
module packet_header_five_tuple_extractor_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_ip_kind,
   output logic [63:0] rsp_src_addr_high,
   output logic [63:0] rsp_src_addr_low,
   output logic [63:0] rsp_dst_addr_high,
   output logic [63:0] rsp_dst_addr_low,
   output logic [15:0] rsp_src_port,
   output logic [15:0] rsp_dst_port,
   output logic        rsp_ports_valid,
   output logic [2:0]  rsp_protocol_class,
   output logic [15:0] rsp_ip_length,
   output logic        rsp_truncated
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_last_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   phfte_pkg::record_type rec_ff;
   phfte_pkg::record_type record;
   logic                  step;
   logic                  req_take;

   // A held item moves on unless it ends a frame while the result register is still full.
   assign step      = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign req_take  = req_valid && req_ready;

   // Input register.
   assign in_valid_in = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last;
      end
   end

   // Frame capture and record assembly.
   phfte_capture u_capture (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .last      (in_last_ff),
      .record    (record)
   );

   // Result register.
   assign rsp_valid_in = (step && in_last_ff) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && in_last_ff) begin
         rec_ff <= record;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ip_kind        = rec_ff.ip_kind;
   assign rsp_src_addr_high  = rec_ff.src_addr_high;
   assign rsp_src_addr_low   = rec_ff.src_addr_low;
   assign rsp_dst_addr_high  = rec_ff.dst_addr_high;
   assign rsp_dst_addr_low   = rec_ff.dst_addr_low;
   assign rsp_src_port       = rec_ff.src_port;
   assign rsp_dst_port       = rec_ff.dst_port;
   assign rsp_ports_valid    = rec_ff.ports_valid;
   assign rsp_protocol_class = rec_ff.protocol_class;
   assign rsp_ip_length      = rec_ff.ip_length;
   assign rsp_truncated      = rec_ff.truncated;

endmodule
